### design/rct_pkg.sv
// Shared types and constants for the RGB channel transform.
// Holds register indexes, operation codes, reset values and stage structs.
// No dependencies.
package rct_pkg;

	// default channel width and fixed field widths
	localparam int CHANNEL_BITS_DEF = 8;
	localparam int OP_W             = 5;
	localparam int THRESH_W         = 17;
	localparam int OFFSET_W         = 8;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 17;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPERATION      = 3'd0,
		REG_KEEP_GRAY      = 3'd1,
		REG_GRAY_THRESHOLD = 3'd2,
		REG_OFFSET_RED     = 3'd3,
		REG_OFFSET_GREEN   = 3'd4,
		REG_OFFSET_BLUE    = 3'd5
	} reg_idx_t;

	// operation codes; codes above OP_RED_SHIFT pass the entry through
	typedef enum logic [OP_W-1:0] {
		OP_R_FROM_G   = 5'd0,
		OP_R_FROM_B   = 5'd1,
		OP_G_FROM_R   = 5'd2,
		OP_G_FROM_B   = 5'd3,
		OP_B_FROM_R   = 5'd4,
		OP_B_FROM_G   = 5'd5,
		OP_SWAP_RG    = 5'd6,
		OP_SWAP_GB    = 5'd7,
		OP_SWAP_BR    = 5'd8,
		OP_HALVE_R    = 5'd9,
		OP_HALVE_G    = 5'd10,
		OP_HALVE_B    = 5'd11,
		OP_DOUBLE_R   = 5'd12,
		OP_DOUBLE_G   = 5'd13,
		OP_DOUBLE_B   = 5'd14,
		OP_DOM_SWAP_R = 5'd15,
		OP_DOM_SWAP_G = 5'd16,
		OP_DOM_SWAP_B = 5'd17,
		OP_ADD_OFFS   = 5'd18,
		OP_SUB_OFFS   = 5'd19,
		OP_RED_SHIFT  = 5'd20,
		OP_PASS       = 5'd31
	} op_t;

	// reset values
	localparam op_t                  OPERATION_RST  = OP_PASS;
	localparam logic [THRESH_W-1:0]  THRESHOLD_RST  = THRESH_W'(1000);

	// configuration registers as seen by the datapath
	typedef struct packed {
		op_t                 operation;
		logic                keep_gray;
		logic [THRESH_W-1:0] gray_threshold;
		logic [OFFSET_W-1:0] offset_red;
		logic [OFFSET_W-1:0] offset_green;
		logic [OFFSET_W-1:0] offset_blue;
	} cfg_t;

	// decisions handed from the analysis stages to the apply stage
	typedef struct packed {
		logic skip;
		logic swap_rb;
		logic swap_rg;
		logic swap_gb;
		logic red_shift;
	} flags_t;

endpackage

### design/rct_cfg.sv
// Configuration register file for the RGB channel transform.
// Depends on rct_pkg (cfg_t, reg_idx_t, reset values).
module rct_cfg import rct_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// one register written per beat; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.operation      <= OPERATION_RST;
			cfg_q.keep_gray      <= 1'b0;
			cfg_q.gray_threshold <= THRESHOLD_RST;
			cfg_q.offset_red     <= '0;
			cfg_q.offset_green   <= '0;
			cfg_q.offset_blue    <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OPERATION:      cfg_q.operation      <= op_t'(cfg_data[OP_W-1:0]);
				REG_KEEP_GRAY:      cfg_q.keep_gray      <= cfg_data[0];
				REG_GRAY_THRESHOLD: cfg_q.gray_threshold <= cfg_data[THRESH_W-1:0];
				REG_OFFSET_RED:     cfg_q.offset_red     <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_GREEN:   cfg_q.offset_green   <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_BLUE:    cfg_q.offset_blue    <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/rct_analyze.sv
// Analysis stages 1 to 3: gray distance, dominance and red-shift tests,
// and the red-shift amount. Depends on rct_pkg (cfg_t, flags_t).
module rct_analyze import rct_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en1,
	input  logic                    en2,
	input  logic                    en3,
	input  cfg_t                    cfg,
	input  logic [CHANNEL_BITS-1:0] red_in,
	input  logic [CHANNEL_BITS-1:0] green_in,
	input  logic [CHANNEL_BITS-1:0] blue_in,
	output logic [CHANNEL_BITS-1:0] red_s3,
	output logic [CHANNEL_BITS-1:0] green_s3,
	output logic [CHANNEL_BITS-1:0] blue_s3,
	output logic [CHANNEL_BITS-1:0] shift_s3,
	output flags_t                  flags_s3
);

	localparam int CB  = CHANNEL_BITS;
	localparam int SQW = 2 * CB;
	localparam int DW  = (SQW + 1 > THRESH_W) ? SQW + 1 : THRESH_W;
	// widest of 1000*x, 1111*(y+z), 100*(y+z), 135*x
	localparam int PW  = CB + 12;
	// floor(x/3) for x below 2^(CB+1): multiply by ceil(2^RS/3), shift by RS
	localparam int RS  = CB + 3;
	localparam logic [RS-1:0] RECIP3 = RS'(((1 << RS) + 2) / 3);
	localparam logic [PW-1:0] K1000  = PW'(1000);
	localparam logic [PW-1:0] K1111  = PW'(1111);
	localparam logic [PW-1:0] K100   = PW'(100);
	localparam logic [PW-1:0] K135   = PW'(135);

	// ---- stage 1: channel differences squared, pair sums, min(g,b)
	logic signed [CB:0]       d_bg, d_br;
	logic signed [2*CB+1:0]   p_bg, p_br;
	logic [CB-1:0]            r_s1, g_s1, b_s1, min_gb_s1;
	logic [SQW-1:0]           sq_bg_s1, sq_br_s1;
	logic [CB:0]              sum_gb_s1, sum_rb_s1, sum_rg_s1;

	assign d_bg = signed'({1'b0, blue_in}) - signed'({1'b0, green_in});
	assign d_br = signed'({1'b0, blue_in}) - signed'({1'b0, red_in});
	assign p_bg = d_bg * d_bg;
	assign p_br = d_br * d_br;

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1      <= red_in;
			g_s1      <= green_in;
			b_s1      <= blue_in;
			sq_bg_s1  <= p_bg[SQW-1:0];
			sq_br_s1  <= p_br[SQW-1:0];
			sum_gb_s1 <= {1'b0, green_in} + {1'b0, blue_in};
			sum_rb_s1 <= {1'b0, red_in} + {1'b0, blue_in};
			sum_rg_s1 <= {1'b0, red_in} + {1'b0, green_in};
			min_gb_s1 <= (blue_in > green_in) ? green_in : blue_in;
		end
	end

	// ---- stage 2: distance sum, constant products, shift amount
	logic [CB-1:0]       r_s2, g_s2, b_s2, shift_s2;
	logic [SQW:0]        dist_s2;
	logic [PW-1:0]       r1000_s2, g1000_s2, b1000_s2;
	logic [PW-1:0]       gb1111_s2, rb1111_s2, rg1111_s2, gb100_s2, r135_s2;
	logic [CB+RS:0]      div_prod;

	assign div_prod = (CB+RS+1)'({min_gb_s1, 1'b0}) * (CB+RS+1)'(RECIP3);

	always_ff @(posedge clk) begin
		if (en2) begin
			r_s2      <= r_s1;
			g_s2      <= g_s1;
			b_s2      <= b_s1;
			dist_s2   <= {1'b0, sq_bg_s1} + {1'b0, sq_br_s1};
			r1000_s2  <= PW'(r_s1) * K1000;
			g1000_s2  <= PW'(g_s1) * K1000;
			b1000_s2  <= PW'(b_s1) * K1000;
			gb1111_s2 <= PW'(sum_gb_s1) * K1111;
			rb1111_s2 <= PW'(sum_rb_s1) * K1111;
			rg1111_s2 <= PW'(sum_rg_s1) * K1111;
			gb100_s2  <= PW'(sum_gb_s1) * K100;
			r135_s2   <= PW'(r_s1) * K135;
			shift_s2  <= div_prod[RS +: CB];
		end
	end

	// ---- stage 3: comparisons become decision flags
	flags_t flags_d;

	always_comb begin
		flags_d.skip      = cfg.keep_gray && (DW'(dist_s2) < DW'(cfg.gray_threshold));
		flags_d.swap_rb   = r1000_s2 > gb1111_s2;
		flags_d.swap_rg   = g1000_s2 > rb1111_s2;
		flags_d.swap_gb   = b1000_s2 > rg1111_s2;
		flags_d.red_shift = gb100_s2 > r135_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			red_s3   <= r_s2;
			green_s3 <= g_s2;
			blue_s3  <= b_s2;
			shift_s3 <= shift_s2;
			flags_s3 <= flags_d;
		end
	end

endmodule

### design/rct_apply.sv
// Stage 4: applies the configured operation, clamps, and holds the result.
// Depends on rct_pkg (cfg_t, flags_t, op_t).
module rct_apply import rct_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en4,
	input  cfg_t                    cfg,
	input  logic [CHANNEL_BITS-1:0] red_s3,
	input  logic [CHANNEL_BITS-1:0] green_s3,
	input  logic [CHANNEL_BITS-1:0] blue_s3,
	input  logic [CHANNEL_BITS-1:0] shift_s3,
	input  flags_t                  flags_s3,
	output logic [CHANNEL_BITS-1:0] red_s4,
	output logic [CHANNEL_BITS-1:0] green_s4,
	output logic [CHANNEL_BITS-1:0] blue_s4,
	output logic                    skip_s4
);

	localparam int CB = CHANNEL_BITS;
	// room for channel plus offset, and for channel minus offset
	localparam int AW = ((CB > OFFSET_W) ? CB : OFFSET_W) + 2;
	localparam logic signed [AW-1:0] CMAX = signed'(AW'({CB{1'b1}}));

	function automatic logic [CB-1:0] clamp_ch(input logic signed [AW-1:0] v);
		logic [CB-1:0] res;
		if (v < 0)
			res = '0;
		else if (v > CMAX)
			res = {CB{1'b1}};
		else
			res = v[CB-1:0];
		return res;
	endfunction

	logic signed [AW-1:0] rx, gx, bx, tx, offr, offg, offb;
	logic signed [AW-1:0] nr, ng, nb;

	assign rx   = signed'(AW'(red_s3));
	assign gx   = signed'(AW'(green_s3));
	assign bx   = signed'(AW'(blue_s3));
	assign tx   = signed'(AW'(shift_s3));
	assign offr = signed'(AW'(cfg.offset_red));
	assign offg = signed'(AW'(cfg.offset_green));
	assign offb = signed'(AW'(cfg.offset_blue));

	// operation select
	always_comb begin
		nr = rx;
		ng = gx;
		nb = bx;
		unique case (cfg.operation)
			OP_R_FROM_G: nr = gx;
			OP_R_FROM_B: nr = bx;
			OP_G_FROM_R: ng = rx;
			OP_G_FROM_B: ng = bx;
			OP_B_FROM_R: nb = rx;
			OP_B_FROM_G: nb = gx;
			OP_SWAP_RG: begin
				nr = gx;
				ng = rx;
			end
			OP_SWAP_GB: begin
				ng = bx;
				nb = gx;
			end
			OP_SWAP_BR: begin
				nb = rx;
				nr = bx;
			end
			OP_HALVE_R:  nr = rx >>> 1;
			OP_HALVE_G:  ng = gx >>> 1;
			OP_HALVE_B:  nb = bx >>> 1;
			OP_DOUBLE_R: nr = rx + rx;
			OP_DOUBLE_G: ng = gx + gx;
			OP_DOUBLE_B: nb = bx + bx;
			OP_DOM_SWAP_R: begin
				if (flags_s3.swap_rb) begin
					nr = bx;
					nb = rx;
				end
			end
			OP_DOM_SWAP_G: begin
				if (flags_s3.swap_rg) begin
					nr = gx;
					ng = rx;
				end
			end
			OP_DOM_SWAP_B: begin
				if (flags_s3.swap_gb) begin
					ng = bx;
					nb = gx;
				end
			end
			OP_ADD_OFFS: begin
				nr = rx + offr;
				ng = gx + offg;
				nb = bx + offb;
			end
			OP_SUB_OFFS: begin
				nr = rx - offr;
				ng = gx - offg;
				nb = bx - offb;
			end
			OP_RED_SHIFT: begin
				if (flags_s3.red_shift) begin
					ng = gx - tx;
					nb = bx - tx;
				end
			end
			default: ;
		endcase
	end

	// result register; a gray entry leaves unchanged
	always_ff @(posedge clk) begin
		if (en4) begin
			skip_s4 <= flags_s3.skip;
			if (flags_s3.skip) begin
				red_s4   <= red_s3;
				green_s4 <= green_s3;
				blue_s4  <= blue_s3;
			end else begin
				red_s4   <= clamp_ch(nr);
				green_s4 <= clamp_ch(ng);
				blue_s4  <= clamp_ch(nb);
			end
		end
	end

endmodule

### design/rgb_channel_transform.sv
// RGB channel transform: one palette entry in, one transformed entry out per
// beat. The datapath is four register stages (squares and sums, constant
// products, compares, operation and clamp), and an entry can be taken every
// cycle while ready is high. Each stage moves on when the stage after it is
// empty or moving, so bubbles close up while the output is stalled; ready
// drops only when all four stages are full and the result is not taken.
// Configuration writes take effect at once and must be made while no entry
// is in flight. Depends on rct_pkg, rct_cfg, rct_analyze and rct_apply.
module rgb_channel_transform import rct_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// entry channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red_in,
	input  logic [CHANNEL_BITS-1:0] green_in,
	input  logic [CHANNEL_BITS-1:0] blue_in,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHANNEL_BITS-1:0] red_out,
	output logic [CHANNEL_BITS-1:0] green_out,
	output logic [CHANNEL_BITS-1:0] blue_out,
	output logic                    skipped_gray
);

	cfg_t                    cfg;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    en1, en2, en3, en4;
	logic [CHANNEL_BITS-1:0] red_s3, green_s3, blue_s3, shift_s3;
	flags_t                  flags_s3;

	assign cfg_ready = 1'b1;

	rct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage enables: a stage loads when it is empty or its successor loads
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	rct_analyze #(.CHANNEL_BITS(CHANNEL_BITS)) u_analyze (
		.clk      (clk),
		.en1      (en1),
		.en2      (en2),
		.en3      (en3),
		.cfg      (cfg),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.red_s3   (red_s3),
		.green_s3 (green_s3),
		.blue_s3  (blue_s3),
		.shift_s3 (shift_s3),
		.flags_s3 (flags_s3)
	);

	rct_apply #(.CHANNEL_BITS(CHANNEL_BITS)) u_apply (
		.clk      (clk),
		.en4      (en4),
		.cfg      (cfg),
		.red_s3   (red_s3),
		.green_s3 (green_s3),
		.blue_s3  (blue_s3),
		.shift_s3 (shift_s3),
		.flags_s3 (flags_s3),
		.red_s4   (red_out),
		.green_s4 (green_out),
		.blue_s4  (blue_out),
		.skip_s4  (skipped_gray)
	);

	assign out_valid = v_s4;

endmodule

### design/rct_checker.sv
// Port-level checker for the RGB channel transform, bound to the top level.
// Depends on rct_pkg for the default channel width.
module rct_checker import rct_pkg::*; #(
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [CHANNEL_BITS-1:0] red_out,
	input logic [CHANNEL_BITS-1:0] green_out,
	input logic [CHANNEL_BITS-1:0] blue_out,
	input logic                    skipped_gray
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(skipped_gray))
		else $error("result beat changed while stalled");

	// an empty output stage never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output stage empty");

	// a draining output keeps the whole pipe moving
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// with no back-pressure a taken entry shows up at the output once it has passed every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind rgb_channel_transform rct_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_rct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.red_out      (red_out),
	.green_out    (green_out),
	.blue_out     (blue_out),
	.skipped_gray (skipped_gray)
);
